>>> hw/rtl/hss_pkg.sv
// Shared types, constants and the exponential bit table for the harmonic spectrum block.
package hss_pkg;

    // fixed field widths
    localparam int unsigned FS_W   = 23;   // fund_step
    localparam int unsigned BF_W   = 24;   // bandwidth_factor
    localparam int unsigned HC_W   = 7;    // harmonic_count, also harmonic number
    localparam int unsigned AMP_W  = 16;
    localparam int unsigned BIN_W  = 17;
    localparam int unsigned BINQ_W = 33;   // bin in UQ.24
    localparam int unsigned BW_W   = 55;   // bandwidth, 48 fraction bits
    localparam int unsigned STR_W  = 65;   // dividend bits streamed into the divider
    localparam int unsigned QUO_W  = 33;
    localparam int unsigned U_W    = 20;   // UQ4.16 exponent argument
    localparam int unsigned CFG_W  = 24;

    localparam logic [1:0] CFG_FUND_STEP = 2'd0;
    localparam logic [1:0] CFG_BW_FACTOR = 2'd1;
    localparam logic [1:0] CFG_HARM_CNT  = 2'd2;

    localparam logic [FS_W-1:0] FS_RESET = 23'd50352;
    localparam logic [BF_W-1:0] BF_RESET = 24'd97206;
    localparam logic [HC_W-1:0] HC_RESET = 7'd64;

    localparam logic [35:0] EXP_CUT = 36'd63191020731;  // 14.71280603 in UQ4.32
    localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // divider request
    typedef struct packed {
        logic              start;
        logic [BW_W-1:0]   rinit;
        logic [STR_W-1:0]  stream;
        logic [6:0]        steps;
        logic [BW_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quot;
        logic              ovf;
    } t_div_rsp;

    // exp(-2^(k-16)) in UQ0.32
    function automatic logic [31:0] exp_bit(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'd4294901760;
            5'd1:  v = 32'd4294836226;
            5'd2:  v = 32'd4294705160;
            5'd3:  v = 32'd4294443040;
            5'd4:  v = 32'd4293918848;
            5'd5:  v = 32'd4292870656;
            5'd6:  v = 32'd4290775039;
            5'd7:  v = 32'd4286586875;
            5'd8:  v = 32'd4278222805;
            5'd9:  v = 32'd4261543595;
            5'd10: v = 32'd4228380000;
            5'd11: v = 32'd4162825044;
            5'd12: v = 32'd4034748382;
            5'd13: v = 32'd3790295335;
            5'd14: v = 32'd3344923893;
            5'd15: v = 32'd2605029347;
            5'd16: v = 32'd1580030169;
            5'd17: v = 32'd581260615;
            5'd18: v = 32'd78665070;
            5'd19: v = 32'd1440801;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/hss_amp_mem.sv
// Amplitude table: synchronous RAM with per-entry valid bits cleared at reset.
module hss_amp_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [hss_pkg::AMP_W-1:0]  i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [hss_pkg::AMP_W-1:0]  o_rdata
);

    logic [hss_pkg::AMP_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]          r_valid;
    logic [hss_pkg::AMP_W-1:0] r_rdata;
    logic                      r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    // never-written entries read as zero
    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

>>> hw/rtl/hss_div.sv
// Shared restoring divider, one quotient bit per cycle.
module hss_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hss_pkg::t_div_req  i_req,
    output hss_pkg::t_div_rsp  o_rsp
);

    logic [hss_pkg::BW_W-1:0]  r_rem;
    logic [hss_pkg::BW_W-1:0]  r_dvs;
    logic [hss_pkg::STR_W-1:0] r_str;
    logic [hss_pkg::QUO_W-1:0] r_quo;
    logic                      r_ovf;
    logic [6:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [hss_pkg::BW_W:0]    w_try;
    logic                      w_bit;

    assign w_try = {r_rem, r_str[hss_pkg::STR_W-1]};
    assign w_bit = (w_try >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rinit;
            r_dvs <= i_req.divisor;
            r_str <= i_req.stream;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_rem <= w_bit ? hss_pkg::BW_W'(w_try - {1'b0, r_dvs})
                           : w_try[hss_pkg::BW_W-1:0];
            r_str <= {r_str[hss_pkg::STR_W-2:0], 1'b0};
            r_quo <= {r_quo[hss_pkg::QUO_W-2:0], w_bit};
            r_ovf <= r_ovf | r_quo[hss_pkg::QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.ovf  = r_ovf;

endmodule

>>> hw/rtl/hss_nexp.sv
// Serial exp(-u): one argument bit per cycle, multiply by the table entry when set.
module hss_nexp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [hss_pkg::U_W-1:0]  i_u,
    output logic                     o_done,
    output logic                     o_one,
    output logic [31:0]              o_e
);

    logic [hss_pkg::U_W-1:0] r_u;
    logic [4:0]              r_k;
    logic [31:0]             r_e;
    logic                    r_one;
    logic                    r_busy;
    logic                    r_done;
    logic [31:0]             w_tab;
    logic [63:0]             w_prod;

    assign w_tab  = hss_pkg::exp_bit(r_k);
    assign w_prod = 64'(r_e) * 64'(w_tab);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u   <= i_u;
            r_e   <= '0;
            r_one <= 1'b1;
        end else if (r_busy) begin
            r_u <= r_u >> 1;
            if (r_u[0]) begin
                r_one <= 1'b0;
                r_e   <= r_one ? w_tab : w_prod[63:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 5'd1;
                if (r_k == 5'(hss_pkg::U_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_one  = r_one;
    assign o_e    = r_e;

endmodule

>>> hw/rtl/harmonic_spectrum_synth.sv
// Harmonic spectrum synthesiser: one bin of a PADsynth magnitude spectrum per query request.
//
// A load request writes one UQ0.16 amplitude into the harmonic table and gives no
// result. A query request walks harmonics 1 .. count-1 one at a time, with the count
// clipped to the table size: read the table entry, form the bandwidth and the centre,
// divide for |x| on the shared bit-serial divider, square, evaluate exp(-x^2) one
// argument bit per cycle, multiply by the amplitude and divide by the bandwidth again.
// A harmonic whose term falls outside the profile window, or whose amplitude or
// bandwidth is zero, is skipped early; a query ends early once the UQ16.16 sum
// saturates. The table clears at reset through valid bits, so no clearing pass
// is needed. Inputs are stalled while a query runs; a finished result waits in the
// output register while the next request is taken. Configuration writes are taken
// at any time but are only meant while the block is idle.
module harmonic_spectrum_synth #(
    parameter int unsigned FFT_SIZE_LOG2 = 18,
    parameter int unsigned MAX_HARMONICS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_addr,
    input  logic [hss_pkg::CFG_W-1:0]    i_cfg_wdata,
    // request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_command,
    input  logic [5:0]                   i_harmonic_index,
    input  logic [hss_pkg::AMP_W-1:0]    i_amplitude,
    input  logic [hss_pkg::BIN_W-1:0]    i_bin_index,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [31:0]                  o_spectrum_value,
    output logic                         o_saturated
);

    localparam int unsigned AW      = (MAX_HARMONICS > 2) ? $clog2(MAX_HARMONICS) : 1;
    localparam int unsigned BIN_SH  = 24 - FFT_SIZE_LOG2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_H0   = 4'd1;   // table read, bandwidth and centre
    localparam logic [3:0] S_H1   = 4'd2;   // window test, start |x| division
    localparam logic [3:0] S_D1   = 4'd3;
    localparam logic [3:0] S_X2   = 4'd4;   // cut test, start exp
    localparam logic [3:0] S_EX   = 4'd5;
    localparam logic [3:0] S_MP   = 4'd6;   // start term division
    localparam logic [3:0] S_D2   = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // configuration registers
    logic [hss_pkg::FS_W-1:0] r_fs;
    logic [hss_pkg::BF_W-1:0] r_bf;
    logic [hss_pkg::HC_W-1:0] r_hc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= hss_pkg::FS_RESET;
            r_bf <= hss_pkg::BF_RESET;
            r_hc <= hss_pkg::HC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                hss_pkg::CFG_FUND_STEP: r_fs <= i_cfg_wdata[hss_pkg::FS_W-1:0];
                hss_pkg::CFG_BW_FACTOR: r_bf <= i_cfg_wdata[hss_pkg::BF_W-1:0];
                hss_pkg::CFG_HARM_CNT:  r_hc <= i_cfg_wdata[hss_pkg::HC_W-1:0];
                default: ;
            endcase
        end
    end

    logic [3:0]                  r_state, n_state;
    logic [hss_pkg::HC_W-1:0]    r_h, r_n;
    logic [hss_pkg::BINQ_W-1:0]  r_binq;
    logic [46:0]                 r_bffs;
    logic [hss_pkg::BW_W-1:0]    r_bw;
    logic [29:0]                 r_centre;
    logic [hss_pkg::AMP_W-1:0]   r_amp;
    logic [35:0]                 r_x2;
    logic [48:0]                 r_prod;
    logic [hss_pkg::QUO_W-1:0]   r_term;
    logic                        r_big;
    logic [31:0]                 r_sum;
    logic                        r_sat;
    logic                        r_ovalid;
    logic [31:0]                 r_oval;
    logic                        r_osat;

    logic                        w_in_acc;
    logic                        w_mem_we;
    logic [hss_pkg::AMP_W-1:0]   w_rdata;
    logic [8:0]                  w_ncl;
    logic [hss_pkg::HC_W-1:0]    w_n;
    logic [hss_pkg::BINQ_W-1:0]  w_d;
    logic [56:0]                 w_num;
    logic                        w_skip;
    logic [17:0]                 w_q;
    logic [33:0]                 w_acc;
    logic                        w_clip;
    logic                        w_out_free;
    logic                        w_exp_done;
    logic                        w_exp_one;
    logic [31:0]                 w_exp_e;
    logic [47:0]                 w_pm;
    hss_pkg::t_div_req           w_dreq;
    hss_pkg::t_div_rsp           w_drsp;

    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;
    assign w_mem_we = w_in_acc && (i_command == hss_pkg::CMD_LOAD)
                      && (32'(i_harmonic_index) < MAX_HARMONICS);

    hss_amp_mem #(
        .DEPTH(MAX_HARMONICS),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (w_mem_we),
        .i_waddr(AW'(i_harmonic_index)),
        .i_wdata(i_amplitude),
        .i_raddr(AW'(r_h)),
        .o_rdata(w_rdata)
    );

    // count clipped to the table size
    assign w_ncl = (9'(r_hc) > 9'(MAX_HARMONICS)) ? 9'(MAX_HARMONICS) : 9'(r_hc);
    assign w_n   = w_ncl[hss_pkg::HC_W-1:0];

    // distance from the harmonic centre, UQ.24, then scaled by 2^24
    assign w_d   = (r_binq >= 33'(r_centre)) ? r_binq - 33'(r_centre)
                                             : 33'(r_centre) - r_binq;
    assign w_num = {w_d, 24'd0};
    assign w_skip = (r_bw == '0) || (w_rdata == '0) || (w_num >= {r_bw, 2'b00});

    assign w_q  = w_drsp.quot[17:0];
    assign w_pm = 48'(r_amp) * 48'(w_exp_e);

    assign w_acc  = 34'(r_sum) + 34'(r_term);
    assign w_clip = r_big || (w_acc > 34'(hss_pkg::SUM_MAX));
    assign w_out_free = !r_ovalid || !i_stall;

    always_comb begin
        w_dreq = '0;
        w_dreq.divisor = r_bw;
        if (r_state == S_H1 && !w_skip) begin
            // quotient < 4: top bits start the remainder, two integer bits + 16 fraction
            w_dreq.start  = 1'b1;
            w_dreq.rinit  = w_num[56:2];
            w_dreq.stream = {w_num[1:0], 63'd0};
            w_dreq.steps  = 7'd18;
        end else if (r_state == S_MP) begin
            w_dreq.start  = 1'b1;
            w_dreq.rinit  = '0;
            w_dreq.stream = {r_prod, 16'd0};
            w_dreq.steps  = 7'(hss_pkg::STR_W);
        end
    end

    hss_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    hss_nexp u_exp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_X2 && r_x2 <= hss_pkg::EXP_CUT),
        .i_u    (r_x2[35:16]),
        .o_done (w_exp_done),
        .o_one  (w_exp_one),
        .o_e    (w_exp_e)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_command == hss_pkg::CMD_QUERY) begin
                    n_state = (w_n <= 7'd1) ? S_DONE : S_H0;
                end
            end
            S_H0:   n_state = S_H1;
            S_H1:   n_state = w_skip ? S_ACC : S_D1;
            S_D1:   n_state = w_drsp.done ? S_X2 : S_D1;
            S_X2:   n_state = (r_x2 > hss_pkg::EXP_CUT) ? S_ACC : S_EX;
            S_EX:   n_state = w_exp_done ? S_MP : S_EX;
            S_MP:   n_state = S_D2;
            S_D2:   n_state = w_drsp.done ? S_ACC : S_D2;
            S_ACC: begin
                if (w_clip || (r_h + 7'd1 >= r_n)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_H0;
                end
            end
            S_DONE: n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sum    <= '0;
            r_sat    <= 1'b0;
            r_h      <= '0;
            r_n      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_command == hss_pkg::CMD_QUERY) begin
                        r_sum <= '0;
                        r_sat <= 1'b0;
                        r_h   <= 7'd1;
                        r_n   <= w_n;
                    end
                end
                S_ACC: begin
                    if (w_clip) begin
                        r_sum <= hss_pkg::SUM_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= w_acc[31:0];
                        r_h   <= r_h + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_binq <= 33'(i_bin_index) << BIN_SH;
                r_bffs <= 47'(r_bf) * 47'(r_fs);
            end
            S_H0: begin
                r_bw     <= 55'(r_bffs) * 55'(r_h);
                r_centre <= 30'(r_fs) * 30'(r_h);
            end
            S_H1: begin
                r_amp  <= w_rdata;
                r_term <= '0;
                r_big  <= 1'b0;
            end
            S_D1: begin
                if (w_drsp.done) begin
                    r_x2 <= 36'(w_q) * 36'(w_q);
                end
            end
            S_EX: begin
                if (w_exp_done) begin
                    r_prod <= w_exp_one ? {1'b0, r_amp, 32'd0} : {1'b0, w_pm};
                end
            end
            S_D2: begin
                if (w_drsp.done) begin
                    r_term <= w_drsp.quot;
                    r_big  <= w_drsp.ovf;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_oval <= r_sum;
                    r_osat <= r_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_spectrum_value = r_oval;
    assign o_saturated      = r_osat;

endmodule

>>> hw/rtl/hss_chk.sv
// Port-level checker for the harmonic spectrum block, bound to the top level.
module hss_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_command,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_spectrum_value,
    input logic        o_saturated
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_spectrum_value))
        else $error("stalled result changed");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_spectrum_value == 32'hFFFF_FFFF)
        else $error("saturated result below maximum");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_command && !o_valid |=> !o_valid)
        else $error("load request produced a result");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall after reset");

endmodule

bind harmonic_spectrum_synth hss_chk u_hss_chk (.*);
